// ----- rtl/sivl_pkg.sv -----
// Package for the signed integer list validator: character codes, limits,
// token mode and error kind types, and character class helpers.
// No dependencies.
package sivl_pkg;

  // Default width of the token counter; the reported count is 16 bits.
  localparam int DefCountWidth = 16;
  localparam int OutCountWidth = 16;

  // Magnitude register holds the digit value, saturating at 2^32.
  localparam int MagWidth  = 33;
  localparam int ProdWidth = 36;
  localparam logic [MagWidth-1:0] MAG_CAP   = 33'h1_0000_0000;
  localparam logic [MagWidth-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [MagWidth-1:0] NEG_LIMIT = 33'h0_8000_0000;

  // Character codes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Token mode, one-hot.
  typedef enum logic [2:0] {
    MODE_GAP    = 3'b001,
    MODE_SIGN   = 3'b010,
    MODE_DIGITS = 3'b100
  } mode_t;

  // Error kind as reported on the result port.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_RANGE    = 2'd2,
    ERR_EMPTY    = 2'd3
  } err_t;

  // Whitespace: space, or tab through carriage return.
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    is_sign = (c == CHAR_PLUS) || (c == CHAR_MINUS);
  endfunction

endpackage

// ----- rtl/signed_int_list_validator.sv -----
// Top level of the signed integer list validator: input register, token
// state update and result register in one module.
// Depends on sivl_pkg.
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+-------------------------
//  input   | in_valid, in_ready, text_char, end_of_text | in  | one character per item
//  result  | out_valid, out_ready, token_count,        | out | one result per end of
//          | accepted, error_kind                      |     | text
//
// One character is taken per cycle unless the input stalls; the token state is
// updated in the cycle after a character is registered, and a result is loaded
// when the end-of-text item moves on from the input register.
// Reset clears the token state, the error flag and both valid flags.
// The input only stalls when an end-of-text item waits in the input register
// while the previous result has not been taken.
module signed_int_list_validator #(
  parameter int COUNT_WIDTH = sivl_pkg::DefCountWidth
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          text_char,
  input  logic                                end_of_text,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sivl_pkg::OutCountWidth-1:0]  token_count,
  output logic                                accepted,
  output logic [1:0]                          error_kind
);
  import sivl_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  // Input register.
  logic       item_valid;
  logic [7:0] char_q;
  logic       eot_q;

  // Token state.
  mode_t                  mode, mode_next;
  logic                   negative, negative_next;
  logic [MagWidth-1:0]    magnitude, magnitude_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  err_t                   error_code, error_code_next;

  // Result register.
  logic [COUNT_WIDTH-1:0] res_count;
  err_t                   res_err;

  logic                   advance;
  logic [ProdWidth-1:0]   mag_prod;
  logic [MagWidth-1:0]    mag_sat;
  logic [MagWidth-1:0]    limit;
  logic [COUNT_WIDTH-1:0] close_count;
  err_t                   close_err;
  err_t                   final_err;

  // The registered item moves on unless it is an end of text facing a full
  // result register.
  assign advance  = item_valid && (!eot_q || !out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      char_q <= text_char;
      eot_q  <= end_of_text;
    end
  end

  // Next magnitude: times ten plus the digit, saturating at the cap.
  assign mag_prod = ({3'b000, magnitude} << 3) + ({3'b000, magnitude} << 1)
                  + ProdWidth'(char_q[3:0]);
  assign mag_sat  = (mag_prod > ProdWidth'(MAG_CAP)) ? MAG_CAP : mag_prod[MagWidth-1:0];
  assign limit    = negative ? NEG_LIMIT : POS_LIMIT;

  // Closing the current token at whitespace or end of text.
  always_comb begin
    close_count = count;
    close_err   = error_code;
    case (mode)
      MODE_GAP: begin
      end
      MODE_SIGN: begin
        close_err = ERR_BAD_CHAR;
      end
      MODE_DIGITS: begin
        if (magnitude > limit) begin
          close_err = ERR_RANGE;
        end else if (count != CountMax) begin
          close_count = count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Error kind reported at end of text.
  always_comb begin
    final_err = close_err;
    if (close_err == ERR_NONE && close_count == '0) begin
      final_err = ERR_EMPTY;
    end
  end

  // Token state update for one registered item.
  always_comb begin
    mode_next       = mode;
    negative_next   = negative;
    magnitude_next  = magnitude;
    count_next      = count;
    error_code_next = error_code;
    if (advance) begin
      if (eot_q) begin
        mode_next       = MODE_GAP;
        negative_next   = 1'b0;
        magnitude_next  = '0;
        count_next      = '0;
        error_code_next = ERR_NONE;
      end else if (error_code == ERR_NONE) begin
        if (is_digit(char_q)) begin
          magnitude_next = mag_sat;
          mode_next      = MODE_DIGITS;
        end else if (is_sign(char_q)) begin
          if (mode == MODE_GAP) begin
            mode_next     = MODE_SIGN;
            negative_next = (char_q == CHAR_MINUS);
          end else begin
            error_code_next = ERR_BAD_CHAR;
          end
        end else if (is_blank(char_q)) begin
          count_next      = close_count;
          error_code_next = close_err;
          mode_next       = MODE_GAP;
          negative_next   = 1'b0;
          magnitude_next  = '0;
        end else begin
          error_code_next = ERR_BAD_CHAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_GAP;
      negative   <= 1'b0;
      magnitude  <= '0;
      count      <= '0;
      error_code <= ERR_NONE;
    end else begin
      mode       <= mode_next;
      negative   <= negative_next;
      magnitude  <= magnitude_next;
      count      <= count_next;
      error_code <= error_code_next;
    end
  end

  // Result register, loaded at end of text.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && eot_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && eot_q) begin
      // An earlier error freezes the count at its value before that error.
      res_count <= (error_code == ERR_NONE) ? close_count : count;
      res_err   <= (error_code == ERR_NONE) ? final_err : error_code;
    end
  end

  assign token_count = OutCountWidth'(res_count);
  assign error_kind  = res_err;
  assign accepted    = (res_err == ERR_NONE);

  // The magnitude never passes its saturation value.
  assert property (@(posedge clk) disable iff (rst) magnitude <= MAG_CAP)
    else $error("magnitude above saturation value");

  // After an end of text the token state is back at its start.
  assert property (@(posedge clk) disable iff (rst)
    advance && eot_q |=> mode == MODE_GAP && count == '0 && error_code == ERR_NONE)
    else $error("state not cleared after end of text");

  // An error stays until the end of text.
  assert property (@(posedge clk) disable iff (rst)
    error_code != ERR_NONE && !(advance && eot_q) |=> error_code == $past(error_code))
    else $error("error flag not sticky");

  // The input side only stalls behind a blocked end of text.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> item_valid && eot_q && out_valid && !out_ready)
    else $error("input stalled without cause");

  // A result never claims success with an error kind set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> error_kind == ERR_NONE)
    else $error("accepted with error");

endmodule

// ----- bench/tb_top.sv -----
// Testbench for signed_int_list_validator: queued character stimulus, a clocked driver and
// monitor, and a predictor of token count, accept flag and error kind per text.
// Depends on sivl_pkg and the signed_int_list_validator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sivl_pkg::*;

  localparam int COUNT_W = DefCountWidth;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam int QUIET_FROM = 1200;
  localparam int QUIET_TO = 1900;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    bit         hold;
  } text_item_t;

  typedef struct {
    logic [OutCountWidth-1:0] count;
    logic                     acc;
    err_t                     kind;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] text_char = 8'h00;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OutCountWidth-1:0] token_count;
  logic accepted;
  logic [1:0] error_kind;

  text_item_t char_queue[$];
  scan_result_t expected_results[$];
  scan_result_t want;
  int mismatch_count = 0;
  int cyc = 0;

  // Predictor state for the text under way.
  mode_t              tok_mode = MODE_GAP;
  logic               tok_neg = 1'b0;
  logic [MagWidth-1:0] tok_mag = '0;
  logic [COUNT_W-1:0] tok_count = '0;
  err_t               scan_err = ERR_NONE;

  signed_int_list_validator i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_char  (text_char),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_count(token_count),
    .accepted   (accepted),
    .error_kind (error_kind)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Random idling, except inside one quiet window of cycles.
  function automatic bit take_break();
    return (cyc < QUIET_FROM || cyc >= QUIET_TO) && ($urandom_range(0, 99) < 17);
  endfunction

  // Ends the token under way at whitespace or end of text.
  task automatic close_token();
    if (tok_mode == MODE_SIGN) begin
      if (scan_err == ERR_NONE) scan_err = ERR_BAD_CHAR;
    end else if (tok_mode == MODE_DIGITS) begin
      if (tok_mag > (tok_neg ? NEG_LIMIT : POS_LIMIT)) begin
        if (scan_err == ERR_NONE) scan_err = ERR_RANGE;
      end else if (tok_count != '1) begin
        tok_count++;
      end
    end
    tok_mode = MODE_GAP;
    tok_neg = 1'b0;
    tok_mag = '0;
  endtask

  // Advances the predictor by one accepted character and queues a result at end of text.
  task automatic scan_char(input logic [7:0] c, input logic eot);
    scan_result_t r;
    logic [ProdWidth-1:0] prod;
    if (eot) begin
      if (scan_err == ERR_NONE) close_token();
      if (scan_err == ERR_NONE && tok_count == 0) scan_err = ERR_EMPTY;
      r.count = OutCountWidth'(tok_count);
      r.acc = (scan_err == ERR_NONE);
      r.kind = scan_err;
      expected_results.push_back(r);
      tok_mode = MODE_GAP;
      tok_neg = 1'b0;
      tok_mag = '0;
      tok_count = '0;
      scan_err = ERR_NONE;
    end else if (scan_err == ERR_NONE) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        prod = ProdWidth'(tok_mag) * ProdWidth'(10) + ProdWidth'(c - CHAR_ZERO);
        tok_mag = (prod > ProdWidth'(MAG_CAP)) ? MAG_CAP : prod[MagWidth-1:0];
        tok_mode = MODE_DIGITS;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        if (tok_mode == MODE_GAP) begin
          tok_mode = MODE_SIGN;
          tok_neg = (c == CHAR_MINUS);
        end else begin
          scan_err = ERR_BAD_CHAR;
        end
      end else begin
        case (c)
          CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR: close_token();
          default: scan_err = ERR_BAD_CHAR;
        endcase
      end
    end
  endtask

  task automatic push_char(input logic [7:0] c, input logic eot = 1'b0, input bit hold = 1'b0);
    text_item_t it;
    it.ch = c;
    it.eot = eot;
    it.hold = hold;
    char_queue.push_back(it);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // One to three whitespace characters of any kind.
  task automatic push_blanks();
    logic [7:0] blanks[6];
    blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
    repeat ($urandom_range(1, 3)) push_char(blanks[$urandom_range(0, 5)]);
  endtask

  // A text of mostly well-formed tokens, some near the range limits, some of them damaged.
  task automatic add_random_text();
    int n_tok;
    int noise_at;
    string digits;
    string tok;
    n_tok = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) push_blanks();
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 9))
        0: digits = "2147483647";
        1: digits = "2147483648";
        2: digits = "2147483649";
        3: digits = "4294967296";
        4: begin
          digits = "";
          repeat ($urandom_range(11, 20)) digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
        end
        5: digits = {"000", $sformatf("%0d", $urandom_range(0, 99999))};
        6, 7: digits = $sformatf("%0d", $urandom_range(0, 999));
        default: digits = $sformatf("%0d", $urandom());
      endcase
      case ($urandom_range(0, 2))
        0: tok = digits;
        1: tok = {"+", digits};
        default: tok = {"-", digits};
      endcase
      noise_at = -1;
      // Now and then the token is damaged in one of several ways.
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: noise_at = $urandom_range(0, tok.len());
          1: tok = ($urandom_range(0, 1) != 0) ? "+" : "-";
          2: tok = {"+-", digits};
          default: tok = {tok, "-"};
        endcase
      end
      for (int i = 0; i <= tok.len(); i++) begin
        if (i == noise_at) push_char(8'($urandom_range(0, 255)));
        if (i < tok.len()) push_char(tok[i]);
      end
      if (t < n_tok - 1 || $urandom_range(0, 1) != 0) push_blanks();
    end
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Driver: predicts on each accepted transaction, then offers the next queued item.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) scan_char(text_char, end_of_text);
      if (!in_valid || in_ready) begin
        if (char_queue.size() != 0 && !take_break() &&
            !(char_queue[0].hold && expected_results.size() != 0)) begin
          in_valid <= 1'b1;
          text_char <= char_queue[0].ch;
          end_of_text <= char_queue[0].eot;
          void'(char_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: count %0d acc %0b kind %0d",
                                    token_count, accepted, error_kind));
        end else begin
          want = expected_results.pop_front();
          if (token_count !== want.count)
            report_mismatch($sformatf("token_count %0d, expected %0d", token_count, want.count));
          if (accepted !== want.acc)
            report_mismatch($sformatf("accepted %0b, expected %0b", accepted, want.acc));
          if (error_kind !== want.kind)
            report_mismatch($sformatf("error_kind %0d, expected %0d", error_kind, want.kind));
        end
      end
      out_ready <= !take_break();
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int start;
    // Directed texts: empty, every kind of whitespace, lone and misplaced signs,
    // the byte 0 and the byte 255, and characters after an error.
    push_char(8'h00, 1'b1);
    push_char(CHAR_TAB);
    push_str("+7");
    push_char(CHAR_LF);
    push_str("-0");
    push_char(CHAR_VT);
    push_char(CHAR_FF);
    push_str("9");
    push_char(CHAR_CR);
    push_char(CHAR_SPACE);
    push_char(8'hFF, 1'b1);
    push_str("+");
    push_char(CHAR_SPACE, 1'b1);
    push_str("+-");
    push_char(8'h00, 1'b1);
    push_str("1-");
    push_char(8'h00, 1'b1);
    push_char(8'h00);
    push_char(8'h00, 1'b1);
    push_char(8'hFF);
    push_str("5");
    push_char(8'hFF, 1'b1);

    // Random texts; the first one waits for every earlier result.
    start = char_queue.size();
    while (char_queue.size() - start < RANDOM_ITEMS) add_random_text();
    char_queue[start].hold = 1'b1;
    repeat (5) add_random_text();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Checked at the falling edge so that the driver's updates have settled.
    while (char_queue.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
